@@ hw/rtl/dcf_pkg.sv @@
// Shared types and constants for the DAG canonical form block.
`default_nettype none

package dcf_pkg;

  // Fixed field widths.
  localparam int MASK_W        = 28;
  localparam int WORD_W        = 64;
  localparam int NODE_CNT_W    = 4;
  localparam int IN_TDATA_W    = 32;
  localparam int APB_DATA_W    = 32;
  localparam int APB_ADDR_W    = 3;

  // Defaults and reset values.
  localparam int                    MAX_NODES_DEF  = 8;
  localparam logic [NODE_CNT_W-1:0] NODE_CNT_RESET = 4'd7;

  // Register index, taken from paddr[2].
  localparam logic REG_NODE_COUNT = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } dcf_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } dcf_cmd_t;

  typedef struct packed {
    logic last;
  } dcf_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/dag_canonical_form.sv @@
// Top level of the DAG canonical form block.
`default_nettype none

// Takes one upper-triangular edge mask per input word and returns the
// smallest n*n-bit grid word over all n! relabelings of the n nodes, with n
// taken from the node_count register (zero reads as one, values above
// MAX_NODES saturate). The block handles one mask at a time: a new mask can
// be taken the cycle after the result is moved into the output register. The
// permutation stepper scores one relabeling per cycle. The output register
// holds the result until it is taken, so the next mask can be accepted and
// worked on meanwhile. Write node_count only while no mask is in progress.
module dag_canonical_form #(
  parameter int MAX_NODES = dcf_pkg::MAX_NODES_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  // APB configuration port.
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire [dcf_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire [dcf_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [dcf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  // Input stream.
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire [dcf_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [27:0] edge_mask
  // Output stream.
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  output logic [dcf_pkg::WORD_W-1:0]      m_axis_tdata   // [63:0] canonical_word
);
  import dcf_pkg::*;

  logic [NODE_CNT_W-1:0] node_count;
  dcf_cmd_t              cmd;
  dcf_stat_t             stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_CNT_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == REG_NODE_COUNT) begin
      node_count <= pwdata[NODE_CNT_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_NODE_COUNT) begin
      prdata = {(APB_DATA_W - NODE_CNT_W)'(0), node_count};
    end else begin
      prdata = '0;
    end
  end

  dcf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  dcf_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .node_count     (node_count),
    .edge_mask      (s_axis_tdata[MASK_W-1:0]),
    .canonical_word (m_axis_tdata)
  );

endmodule

`default_nettype wire

@@ hw/rtl/dcf_ctrl.sv @@
// Sequencer for the DAG canonical form block: load, permutation sweep, result handoff.
`default_nettype none

module dcf_ctrl (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire             out_ready,
  output dcf_pkg::dcf_cmd_t  cmd,
  input  dcf_pkg::dcf_stat_t stat
);
  import dcf_pkg::*;

  dcf_state_t state, state_next;
  logic       out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_full <= 1'b1;
      end else if (out_ready) begin
        out_full <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (stat.last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last score is folded into the running minimum here.
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_full || out_ready) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_full;

endmodule

`default_nettype wire

@@ hw/rtl/dcf_datapath.sv @@
// Permutation stepper, relabeled-word scorer and running minimum.
`default_nettype none

module dcf_datapath #(
  parameter int MAX_NODES = dcf_pkg::MAX_NODES_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  dcf_pkg::dcf_cmd_t               cmd,
  output dcf_pkg::dcf_stat_t              stat,
  input  wire [dcf_pkg::NODE_CNT_W-1:0]   node_count,
  input  wire [dcf_pkg::MASK_W-1:0]       edge_mask,
  output logic [dcf_pkg::WORD_W-1:0]      canonical_word
);
  import dcf_pkg::*;

  localparam int IW     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int MIDX_W = $clog2(MASK_W);
  localparam int POS_W  = $clog2(WORD_W);
  localparam int PROD_W = IW + NODE_CNT_W + 1;
  localparam int BIDX_W = 2 * NODE_CNT_W + 1;

  logic [MAX_NODES-1:0][IW-1:0]        perm;
  logic [MAX_NODES-1:0][IW-1:0]        perm_next;
  logic [MAX_NODES-1:0][MAX_NODES-1:0] pair_bit;
  logic [MAX_NODES-1:0][MAX_NODES-1:0] pair_load;
  logic [NODE_CNT_W-1:0]               n_reg;
  logic [NODE_CNT_W-1:0]               n_eff;
  logic [WORD_W-1:0]                   score_word;
  logic [WORD_W-1:0]                   score_now;
  logic                                score_valid;
  logic [WORD_W-1:0]                   best;
  logic                                found_k;
  logic [IW-1:0]                       k_idx;
  logic [IW-1:0]                       l_idx;
  logic [IW-1:0]                       val_k;
  logic [IW-1:0]                       val_l;

  // Node count as used: zero counts as one, large values saturate.
  always_comb begin
    if (node_count == '0) begin
      n_eff = NODE_CNT_W'(1);
    end else if (node_count > NODE_CNT_W'(MAX_NODES)) begin
      n_eff = NODE_CNT_W'(MAX_NODES);
    end else begin
      n_eff = node_count;
    end
  end

  // Spread the row-major pair bits onto an (i,j) grid once per item.
  always_comb begin : pair_map
    logic [BIDX_W-1:0] bidx;
    pair_load = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      for (int j = 0; j < MAX_NODES; j++) begin
        bidx = BIDX_W'(i) * BIDX_W'(n_eff) + BIDX_W'(j)
             - BIDX_W'(i * (i + 1) / 2 + i + 1);
        if (j > i && NODE_CNT_W'(j) < n_eff && bidx < BIDX_W'(MASK_W)) begin
          pair_load[i][j] = edge_mask[bidx[MIDX_W-1:0]];
        end
      end
    end
  end

  // Next lexicographic permutation: find the last ascent k, the last entry
  // above perm[k], swap them and reverse the tail.
  always_comb begin : next_perm
    logic [NODE_CNT_W:0] r_full;
    logic [IW-1:0]       r_idx;
    logic [IW-1:0]       r_val;
    found_k = 1'b0;
    k_idx   = '0;
    for (int m = 0; m < MAX_NODES - 1; m++) begin
      if (NODE_CNT_W'(m + 1) < n_reg && perm[m] < perm[m+1]) begin
        found_k = 1'b1;
        k_idx   = IW'(m);
      end
    end
    val_k = '0;
    for (int m = 0; m < MAX_NODES; m++) begin
      if (IW'(m) == k_idx) begin
        val_k = perm[m];
      end
    end
    l_idx = k_idx;
    for (int m = 0; m < MAX_NODES; m++) begin
      if (NODE_CNT_W'(m) < n_reg && IW'(m) > k_idx && perm[m] > val_k) begin
        l_idx = IW'(m);
      end
    end
    val_l = '0;
    for (int m = 0; m < MAX_NODES; m++) begin
      if (IW'(m) == l_idx) begin
        val_l = perm[m];
      end
    end
    for (int m = 0; m < MAX_NODES; m++) begin
      r_full = {1'b0, n_reg} + (NODE_CNT_W+1)'(k_idx) - (NODE_CNT_W+1)'(m);
      r_idx  = r_full[IW-1:0];
      r_val  = '0;
      for (int s = 0; s < MAX_NODES; s++) begin
        if (IW'(s) == r_idx) begin
          r_val = perm[s];
        end
      end
      if (IW'(m) < k_idx || NODE_CNT_W'(m) >= n_reg) begin
        perm_next[m] = perm[m];
      end else if (IW'(m) == k_idx) begin
        perm_next[m] = val_l;
      end else if (r_idx == l_idx) begin
        perm_next[m] = val_k;
      end else begin
        perm_next[m] = r_val;
      end
    end
  end

  assign stat.last = !found_k;

  // Relabeled grid word for the current permutation.
  always_comb begin : scorer
    logic [PROD_W-1:0] pos;
    score_now = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      for (int j = i + 1; j < MAX_NODES; j++) begin
        pos = PROD_W'(perm[i]) * PROD_W'(n_reg) + PROD_W'(perm[j]);
        if (pair_bit[i][j]) begin
          score_now = score_now | (WORD_W'(1) << pos[POS_W-1:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      score_valid <= 1'b0;
    end else begin
      score_valid <= cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_reg    <= n_eff;
      pair_bit <= pair_load;
      best     <= '1;
      for (int m = 0; m < MAX_NODES; m++) begin
        perm[m] <= IW'(m);
      end
    end else begin
      if (cmd.step) begin
        score_word <= score_now;
        perm       <= perm_next;
      end
      if (score_valid && score_word < best) begin
        best <= score_word;
      end
    end
    if (cmd.publish) begin
      canonical_word <= best;
    end
  end

endmodule

`default_nettype wire
